### rtl/core/chained_hash_table_multiplicative_macros.svh
// Assertion helpers shared by the checker.
`ifndef CHAINED_HASH_TABLE_MULTIPLICATIVE_MACROS_SVH
`define CHAINED_HASH_TABLE_MULTIPLICATIVE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cht check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cht check failed");

`endif

### rtl/core/cht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;

  localparam int KEY_W    = 31;
  localparam int KIND_W   = 2;
  localparam int BUCKET_W = 6;
  localparam int TS_W     = 7;
  localparam int MF_W     = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_BUCKETS       = 64;
  localparam int DEF_POOL          = 32;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int MAX_RESULTS       = 32;

  localparam logic [TS_W-1:0] TS_RESET = 7'd64;
  localparam logic [MF_W-1:0] MF_RESET = 16'd40503;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_FRAC  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd3;

  typedef struct packed {
    logic                last;
    logic                full_res;
    logic                found;
    logic [KEY_W-1:0]    key_out;
    logic [BUCKET_W-1:0] bucket;
  } res_t;

endpackage
`default_nettype wire

### rtl/core/cht_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_front #(
  parameter int BUCKETS       = cht_pkg::DEF_BUCKETS,
  parameter int FRACTION_BITS = cht_pkg::DEF_FRACTION_BITS,
  parameter int BW            = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cht_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [cht_pkg::KIND_W-1:0] in_kind_i,
  input  wire logic [cht_pkg::KEY_W-1:0]  in_key_i,
  output logic                            push_o,
  input  wire logic                       full_i,
  output logic [cht_pkg::KIND_W+cht_pkg::KEY_W+BW-1:0] push_data_o
);
  import cht_pkg::*;

  localparam int FB = FRACTION_BITS;

  logic [TS_W-1:0] ts_q;
  logic [MF_W-1:0] mf_q;
  logic [TS_W-1:0] n_eff;

  logic              va_q, vb_q;
  logic [KIND_W-1:0] kind_a_q, kind_b_q;
  logic [KEY_W-1:0]  key_a_q, key_b_q;
  logic [FB-1:0]     frac_a_q;
  logic [BW-1:0]     bkt_b_q;
  logic [KEY_W+MF_W-1:0] prod1;
  logic [TS_W+FB-1:0]    prod2;
  logic [TS_W-1:0]       prod2_hi;
  logic adv_b, acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TS_RESET;
      mf_q <= MF_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TABLE_SIZE) ts_q <= cfg_wdata_i[TS_W-1:0];
      if (cfg_idx_i == CFG_MULT_FRAC)  mf_q <= cfg_wdata_i[MF_W-1:0];
    end
  end

  // 0 acts as 1, anything past the built bucket count is clamped
  always_comb begin
    if (ts_q == '0) n_eff = TS_W'(1);
    else if (32'(ts_q) > BUCKETS) n_eff = TS_W'(BUCKETS);
    else n_eff = ts_q;
  end

  assign prod1    = in_key_i * mf_q;
  assign prod2    = n_eff * frac_a_q;
  assign prod2_hi = prod2[FB +: TS_W];

  assign push_o     = vb_q && !full_i;
  assign adv_b      = !vb_q || push_o;
  assign in_ready_o = !va_q || adv_b;
  assign acc        = in_valid_i && in_ready_o;
  assign push_data_o = {kind_b_q, key_b_q, bkt_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (in_ready_o) va_q <= in_valid_i;
      if (adv_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      kind_a_q <= in_kind_i;
      key_a_q  <= in_key_i;
      frac_a_q <= prod1[FB-1:0];
    end
    if (adv_b && va_q) begin
      kind_b_q <= kind_a_q;
      key_b_q  <= key_a_q;
      bkt_b_q  <= BW'(prod2_hi);
    end
  end

endmodule
`default_nettype wire

### rtl/core/cht_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule
`default_nettype wire

### rtl/core/cht_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_back #(
  parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
  parameter int POOL    = cht_pkg::DEF_POOL,
  parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output logic               q_pop_o,
  input  wire logic [cht_pkg::KIND_W+cht_pkg::KEY_W+BW-1:0] q_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cht_pkg::res_t      out_res_o
);
  import cht_pkg::*;

  localparam int PW  = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int CW  = $clog2(MAX_RESULTS + 1);
  localparam logic [BW-1:0] B_LAST = BW'(BUCKETS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HRD  = 3'd1;
  localparam logic [2:0] S_HCHK = 3'd2;
  localparam logic [2:0] S_NRD  = 3'd3;
  localparam logic [2:0] S_NCHK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_SCAN = 3'd6;
  localparam logic [2:0] S_DEND = 3'd7;

  logic [2:0] st_q;

  logic [PW-1:0]    head_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [POOL];
  logic [PW-1:0]    link_mem [POOL];
  logic [BUCKETS-1:0] head_vld_q;
  logic [POOL-1:0]    link_vld_q;
  logic [POOL-1:0]    free_q;
  logic [PW-1:0]    hd_rd_q, lk_rd_q;
  logic [KEY_W-1:0] ky_rd_q;

  logic [KIND_W-1:0] kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [BW-1:0]     b_q;
  logic [PW-1:0]     ptr_q, prev_q, hptr_q;
  logic              prev_ok_q, found_q;
  logic [CW-1:0]     cnt_q;
  logic              pend_vq;
  logic [BW-1:0]     pend_b_q;
  logic [KEY_W-1:0]  pend_key_q;

  logic   out_vq;
  res_t   res_q;
  logic   can_emit, emit;
  res_t   emit_res;

  logic [PW-1:0] alloc_idx;
  logic          pool_empty;

  // mutation strobes, all issued in S_DONE
  logic do_ins, do_del;

  assign q_pop_o     = (st_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_vq;
  assign out_res_o   = res_q;
  assign can_emit    = !out_vq || out_ready_i;
  assign pool_empty  = (free_q == '0);

  always_comb begin
    alloc_idx = '0;
    for (int i = POOL - 1; i >= 0; i--) begin
      if (free_q[i]) alloc_idx = PW'(i);
    end
  end

  assign do_ins = (st_q == S_DONE) && can_emit && (kind_q == KIND_INSERT) &&
                  !found_q && !pool_empty;
  assign do_del = (st_q == S_DONE) && can_emit && (kind_q == KIND_DELETE) && found_q;

  // result selection
  always_comb begin
    emit     = 1'b0;
    emit_res = '0;
    case (st_q)
      S_DONE: begin
        emit              = can_emit;
        emit_res.bucket   = BUCKET_W'(b_q);
        emit_res.key_out  = key_q;
        emit_res.found    = found_q;
        emit_res.full_res = (kind_q == KIND_INSERT) && !found_q && pool_empty;
        emit_res.last     = 1'b1;
      end
      S_NCHK: begin
        emit             = (kind_q == KIND_DUMP) && pend_vq && can_emit;
        emit_res.bucket  = BUCKET_W'(pend_b_q);
        emit_res.key_out = pend_key_q;
        emit_res.found   = 1'b1;
      end
      S_DEND: begin
        emit = can_emit;
        if (pend_vq) begin
          emit_res.bucket  = BUCKET_W'(pend_b_q);
          emit_res.key_out = pend_key_q;
          emit_res.found   = 1'b1;
        end
        emit_res.last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (emit) begin
      out_vq <= 1'b1;
    end else if (out_ready_i) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= emit_res;
  end

  // memories: registered reads, single write port each
  always_ff @(posedge clk_i) begin
    hd_rd_q <= head_mem[b_q];
    ky_rd_q <= key_mem[ptr_q];
    lk_rd_q <= link_mem[ptr_q];
    if (do_ins) begin
      head_mem[b_q]      <= alloc_idx;
      key_mem[alloc_idx] <= key_q;
      link_mem[alloc_idx] <= hptr_q;
    end else if (do_del) begin
      if (prev_ok_q) link_mem[prev_q] <= lk_rd_q;
      else head_mem[b_q] <= lk_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      link_vld_q <= '0;
      free_q     <= '1;
    end else if (do_ins) begin
      head_vld_q[b_q]       <= 1'b1;
      link_vld_q[alloc_idx] <= head_vld_q[b_q];
      free_q[alloc_idx]     <= 1'b0;
    end else if (do_del) begin
      if (prev_ok_q) link_vld_q[prev_q] <= link_vld_q[ptr_q];
      else head_vld_q[b_q] <= link_vld_q[ptr_q];
      free_q[ptr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      pend_vq <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            pend_vq <= 1'b0;
            cnt_q   <= '0;
            if (q_data_i[KEY_W+BW +: KIND_W] == KIND_DUMP) st_q <= S_SCAN;
            else st_q <= S_HRD;
          end
        end
        S_HRD: st_q <= S_HCHK;
        S_HCHK: begin
          if (head_vld_q[b_q]) st_q <= S_NRD;
          else st_q <= S_DONE;
        end
        S_NRD: st_q <= S_NCHK;
        S_NCHK: begin
          if (kind_q != KIND_DUMP) begin
            if (ky_rd_q == key_q || !link_vld_q[ptr_q]) st_q <= S_DONE;
            else st_q <= S_NRD;
          end else if (!pend_vq || can_emit) begin
            pend_vq <= 1'b1;
            cnt_q   <= cnt_q + CW'(1);
            if (cnt_q + CW'(1) == CW'(MAX_RESULTS)) st_q <= S_DEND;
            else if (link_vld_q[ptr_q]) st_q <= S_NRD;
            else if (b_q == B_LAST) st_q <= S_DEND;
            else st_q <= S_SCAN;
          end
        end
        S_DONE: if (can_emit) st_q <= S_IDLE;
        S_SCAN: begin
          if (head_vld_q[b_q]) st_q <= S_HRD;
          else if (b_q == B_LAST) st_q <= S_DEND;
        end
        S_DEND: if (can_emit) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers of the walk
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          kind_q <= q_data_i[KEY_W+BW +: KIND_W];
          key_q  <= q_data_i[BW +: KEY_W];
          if (q_data_i[KEY_W+BW +: KIND_W] == KIND_DUMP) b_q <= '0;
          else b_q <= q_data_i[BW-1:0];
        end
        found_q   <= 1'b0;
        prev_ok_q <= 1'b0;
      end
      S_HCHK: begin
        hptr_q    <= hd_rd_q;
        ptr_q     <= hd_rd_q;
        found_q   <= 1'b0;
        prev_ok_q <= 1'b0;
      end
      S_NCHK: begin
        if (kind_q != KIND_DUMP) begin
          if (ky_rd_q == key_q) begin
            found_q <= 1'b1;
          end else begin
            prev_q    <= ptr_q;
            prev_ok_q <= 1'b1;
            if (link_vld_q[ptr_q]) ptr_q <= lk_rd_q;
          end
        end else if (!pend_vq || can_emit) begin
          pend_b_q   <= b_q;
          pend_key_q <= ky_rd_q;
          if (link_vld_q[ptr_q]) ptr_q <= lk_rd_q;
          else if (b_q != B_LAST) b_q <= b_q + BW'(1);
        end
      end
      S_SCAN: begin
        if (!head_vld_q[b_q] && b_q != B_LAST) b_q <= b_q + BW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/chained_hash_table_multiplicative.sv
// Channel   | Dir | Payload                                        | Handshake
// s_axis    | in  | tdata: key[30:0]; tuser: kind[1:0]             | tvalid/tready
// m_axis    | out | tdata: bucket, key_out, found, full_res; tlast | tvalid/tready
// cfg       | in  | cfg_idx_i, cfg_wdata_i                         | cfg_we_i
// Front hashes in two multiply stages; a two-word queue feeds the chain walker.
// Insert, delete, find: read the bucket head, then walk the chain node by node (registered memory reads).
// Dump: scans the buckets in order and lists the keys of each non-empty bucket, up to MAX_RESULTS keys.
// Reset clears head and link valid bits and frees the whole node pool at once.
// Either side may stall; the output register frees the walker while a word waits.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table_multiplicative #(
  parameter int BUCKETS       = cht_pkg::DEF_BUCKETS,
  parameter int POOL          = cht_pkg::DEF_POOL,
  parameter int FRACTION_BITS = cht_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cht_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // key[30:0]
  input  wire logic [1:0]                    s_axis_tuser,  // kind[1:0]
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // bucket[5:0], key_out[36:6], found[37], full_res[38]
  output logic [39:0]                        m_axis_tdata,
  output logic                               m_axis_tlast
);
  import cht_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = KIND_W + KEY_W + BW;

  logic          push, qfull, qvalid, qpop;
  logic [QW-1:0] push_data, qdata;
  res_t          res;

  cht_front #(
    .BUCKETS(BUCKETS), .FRACTION_BITS(FRACTION_BITS), .BW(BW)
  ) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_key_i   (s_axis_tdata[KEY_W-1:0]),
    .push_o     (push),
    .full_i     (qfull),
    .push_data_o(push_data)
  );

  cht_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (qfull),
    .valid_o    (qvalid),
    .pop_i      (qpop),
    .data_o     (qdata)
  );

  cht_back #(.BUCKETS(BUCKETS), .POOL(POOL), .BW(BW)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i  (qvalid),
    .q_pop_o    (qpop),
    .q_data_i   (qdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res)
  );

  assign m_axis_tdata = {1'b0, res.full_res, res.found, res.key_out, res.bucket};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

### rtl/core/cht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_table_multiplicative_macros.svh"
module cht_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  // a word held back by the sink must not change
  `CHT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // a failed insert is never also a hit
  `CHT_ASSERT_IMPL(a_full_nohit, m_axis_tvalid && m_axis_tdata[38], !m_axis_tdata[37])
  // only dump entries come without last, and those are always hits
  `CHT_ASSERT_IMPL(a_miss_last, m_axis_tvalid && !m_axis_tdata[37], m_axis_tlast)
  // spare pad bit stays clear
  `CHT_ASSERT_IMPL(a_pad, m_axis_tvalid, !m_axis_tdata[39])
endmodule

bind chained_hash_table_multiplicative cht_checker u_cht_checker (.*);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import cht_pkg::*;

  localparam int NBKT = 64;
  localparam int NPOOL = 32;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [5:0]  bucket;
    logic [30:0] key_out;
    logic        found;
    logic        full_res;
    logic        last;
  } word_t;

  // Software copy of the hash set: predicts the result words of each op.
  class hash_set_sb;
    int unsigned tsize;
    int unsigned mult;
    int unsigned heads[NBKT];
    bit          head_ok[NBKT];
    int unsigned nkey[NPOOL];
    int unsigned nlink[NPOOL];
    bit          link_ok[NPOOL];
    bit          in_use[NPOOL];
    word_t       pending[$];
    int          errors;

    function new();
      tsize = TS_RESET;
      mult = MF_RESET;
      foreach (head_ok[i]) head_ok[i] = 0;
      foreach (in_use[i]) in_use[i] = 0;
      errors = 0;
    endfunction

    function int unsigned bucket_of(logic [30:0] key);
      longint unsigned n;
      longint unsigned frac;
      n = tsize;
      if (n < 1) n = 1;
      if (n > NBKT) n = NBKT;
      frac = (longint'(key) * longint'(mult)) & 64'hFFFF;
      return int'((n * frac) >> 16);
    endfunction

    function void push(logic [5:0] b, logic [30:0] k, logic f, logic fu, logic l);
      word_t w;
      w.bucket = b; w.key_out = k; w.found = f; w.full_res = fu; w.last = l;
      pending.push_back(w);
    endfunction

    function void note_op(logic [1:0] kind, logic [30:0] key);
      int unsigned b, p, prev, node, steps, cnt, free_i;
      bit ok, hit, prev_ok;
      if (kind == KIND_DUMP) begin
        cnt = 0;
        for (int bb = 0; bb < NBKT; bb++) begin
          ok = head_ok[bb]; p = heads[bb]; steps = 0;
          while (ok && steps < NPOOL && cnt < MAX_RESULTS) begin
            push(bb[5:0], nkey[p][30:0], 1'b1, 1'b0, 1'b0);
            cnt++; ok = link_ok[p]; p = nlink[p]; steps++;
          end
        end
        if (cnt == 0) push('0, '0, 1'b0, 1'b0, 1'b1);
        else pending[pending.size()-1].last = 1'b1;
        return;
      end
      b = bucket_of(key);
      ok = head_ok[b]; p = heads[b]; steps = 0; hit = 0; prev_ok = 0; prev = 0; node = 0;
      while (ok && steps < NPOOL && !hit) begin
        if (nkey[p] == key) begin
          hit = 1; node = p;
        end else begin
          prev = p; prev_ok = 1; ok = link_ok[p]; p = nlink[p]; steps++;
        end
      end
      if (kind == KIND_INSERT) begin
        free_i = NPOOL;
        if (!hit)
          for (int i = NPOOL - 1; i >= 0; i--) if (!in_use[i]) free_i = i;
        if (!hit && free_i < NPOOL) begin
          in_use[free_i] = 1; nkey[free_i] = key;
          nlink[free_i] = heads[b]; link_ok[free_i] = head_ok[b];
          heads[b] = free_i; head_ok[b] = 1;
        end
        push(b[5:0], key, hit, !hit && free_i == NPOOL, 1'b1);
      end else begin
        if (kind == KIND_DELETE && hit) begin
          if (prev_ok) begin
            nlink[prev] = nlink[node]; link_ok[prev] = link_ok[node];
          end else begin
            heads[b] = nlink[node]; head_ok[b] = link_ok[node];
          end
          in_use[node] = 0;
        end
        push(b[5:0], key, hit, 1'b0, 1'b1);
      end
    endfunction

    function void check_word(word_t a);
      word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word bucket=%0d key=%0d", $time, a.bucket, a.key_out);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.bucket !== e.bucket) begin
        $display("%0t: bucket exp %0d act %0d", $time, e.bucket, a.bucket); errors++;
      end
      if (a.key_out !== e.key_out) begin
        $display("%0t: key_out exp %0d act %0d", $time, e.key_out, a.key_out); errors++;
      end
      if (a.found !== e.found) begin
        $display("%0t: found exp %0b act %0b", $time, e.found, a.found); errors++;
      end
      if (a.full_res !== e.full_res) begin
        $display("%0t: full_res exp %0b act %0b", $time, e.full_res, a.full_res); errors++;
      end
      if (a.last !== e.last) begin
        $display("%0t: last exp %0b act %0b", $time, e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;  // key[30:0]
  logic [1:0]           s_axis_tuser;  // kind[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [39:0]          m_axis_tdata;  // bucket, key_out, found, full_res
  logic                 m_axis_tlast;

  hash_set_sb sb;
  int idle_cycles;
  logic [30:0] used_keys[$];

  chained_hash_table_multiplicative u_top (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
  end

  // Output side: stall pattern, check each word taken.
  initial begin
    int mode;
    word_t w;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        w.bucket = m_axis_tdata[5:0];
        w.key_out = m_axis_tdata[36:6];
        w.found = m_axis_tdata[37];
        w.full_res = m_axis_tdata[38];
        w.last = m_axis_tlast;
        sb.check_word(w);
      end
      mode = ($time / 20000) % 3;
      if (mode == 0) m_axis_tready <= 1'b1;
      else if (mode == 1) m_axis_tready <= ($urandom_range(3) != 0);
      else m_axis_tready <= ($urandom_range(3) == 0);
    end
  end

  // Watchdog on stalled progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  int burst_left;

  task automatic send_word(logic [1:0] kind, logic [30:0] key);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, key};
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(kind, key);
    used_keys.push_back(key);
    burst_left--;
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    if (burst_left != 0) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TABLE_SIZE) sb.tsize = val[6:0];
    else sb.mult = val;
    @(posedge clk_i);
  endtask

  function automatic logic [30:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(2) != 0)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    case ($urandom_range(3))
      0: return 31'($urandom_range(40));
      1: return 31'h7FFF_FFFF - 31'($urandom_range(3));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    logic [1:0] kind;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) kind = KIND_INSERT;
      else if (r < 70) kind = KIND_DELETE;
      else if (r < 95) kind = KIND_FIND;
      else kind = KIND_DUMP;
      send_word(kind, pick_key());
    end
  endtask

  initial begin
    logic [15:0] ts_vals[6];
    sb = new();
    idle_cycles = 0;
    burst_left = 0;
    cfg_we_i = 0; cfg_idx_i = '0; cfg_wdata_i = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed: empty dump, extremes, duplicates, absent delete
    send_word(KIND_DUMP, 31'h7FFF_FFFF);
    send_word(KIND_FIND, '0);
    send_word(KIND_INSERT, '0);
    send_word(KIND_INSERT, 31'h7FFF_FFFF);
    send_word(KIND_INSERT, 31'h5555_5555);
    send_word(KIND_INSERT, 31'h2AAA_AAAA);
    send_word(KIND_INSERT, '0);
    send_word(KIND_FIND, 31'h7FFF_FFFF);
    send_word(KIND_DELETE, 31'd12345);
    send_word(KIND_DELETE, 31'h5555_5555);
    send_word(KIND_DUMP, '0);
    drain();

    // one bucket: long chain, then fill the pool and overflow
    write_reg(CFG_TABLE_SIZE, 16'd1);
    write_reg(CFG_MULT_FRAC, 16'hFFFF);
    for (int i = 1; i <= 34; i++) send_word(KIND_INSERT, 31'(i * 1000 + 7));
    send_word(KIND_DUMP, '0);
    send_word(KIND_DELETE, 31'd17007);
    send_word(KIND_DELETE, 31'd34007);
    send_word(KIND_INSERT, 31'd99);
    drain();

    // table size above the built count, and zero
    write_reg(CFG_TABLE_SIZE, 16'd127);
    write_reg(CFG_MULT_FRAC, 16'd0);
    random_phase(20);
    drain();
    write_reg(CFG_TABLE_SIZE, 16'd0);
    random_phase(20);
    drain();

    ts_vals = '{16'd64, 16'd7, 16'd1, 16'd33, 16'd64, 16'd2};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_TABLE_SIZE, ts_vals[ph]);
      write_reg(CFG_MULT_FRAC, (ph == 4) ? MF_RESET : 16'($urandom));
      random_phase(40);
      drain();
      if (ph == 2) begin
        for (int k = 0; k < 30; k++) send_word(KIND_DELETE, pick_key());
        drain();
      end
    end
    send_word(KIND_DUMP, '0);
    drain();

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
